// ===== sv/cossim_pkg.sv =====
package cossim_pkg;

    localparam int DOT_W      = 42;
    localparam int NORM_W     = 41;
    localparam int MAG_W      = 42;
    localparam int MUL_W      = 2 * MAG_W;
    localparam int P_W        = 2 * NORM_W;
    localparam int FRAC_SH    = 30;
    localparam int DVD_W      = MUL_W + FRAC_SH;
    localparam int RAD_W      = 30;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQREM_W    = ROOT_W + 2;
    localparam int SIM_W      = 16;
    localparam int ONE_Q14    = 16384;
    localparam int MUL_STEPS  = MAG_W;
    localparam int DIV_STEPS  = DVD_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    typedef struct packed {
        logic take;
        logic load;
        logic mulp_step;
        logic muld_step;
        logic div_step;
        logic sqrt_step;
        logic last_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic zero_norm;
    } status_t;

endpackage

// ===== sv/cossim_ctrl.sv =====
module cossim_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 last,
    input  logic                 result_ready,
    input  cossim_pkg::status_t  status,
    output logic                 item_ready,
    output logic                 result_valid,
    output cossim_pkg::cmd_t     cmd
);

    typedef enum logic [6:0] {
        S_ACC   = 7'b0000001,
        S_DRAIN = 7'b0000010,
        S_LOAD  = 7'b0000100,
        S_MULP  = 7'b0001000,
        S_MULD  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_SQRT  = 7'b1000000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic                           out_wait_reg;
    logic                           out_wait_next;
    logic [cossim_pkg::CNT_W-1:0]   cnt_reg;
    logic [cossim_pkg::CNT_W-1:0]   cnt_next;
    logic                           res_valid_reg;
    logic                           res_valid_next;
    logic                           mul_end;
    logic                           div_end;
    logic                           sqrt_end;

    assign mul_end  = (cnt_reg == cossim_pkg::CNT_W'(cossim_pkg::MUL_STEPS - 1));
    assign div_end  = (cnt_reg == cossim_pkg::CNT_W'(cossim_pkg::DIV_STEPS - 1));
    assign sqrt_end = (cnt_reg == cossim_pkg::CNT_W'(cossim_pkg::SQRT_STEPS - 1));

    assign item_ready   = (state_reg == S_ACC) && !out_wait_reg;
    assign result_valid = res_valid_reg;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        out_wait_next = out_wait_reg;
        cnt_next      = cnt_reg;
        cmd.take      = item_valid && item_ready;
        if (out_wait_reg)
        begin
            // finished result waits for the output register
            if (!res_valid_reg || result_ready)
            begin
                cmd.out_load  = 1'b1;
                out_wait_next = 1'b0;
                state_next    = S_ACC;
            end
        end
        else
        begin
            unique case (state_reg)
                S_ACC:
                begin
                    if (cmd.take && last)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    state_next = S_LOAD;
                end
                S_LOAD:
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (status.zero_norm)
                    begin
                        out_wait_next = 1'b1;
                        state_next    = S_ACC;
                    end
                    else
                    begin
                        state_next = S_MULP;
                    end
                end
                S_MULP:
                begin
                    cmd.mulp_step = 1'b1;
                    cmd.last_step = mul_end;
                    cnt_next      = mul_end ? '0 : cnt_reg + 1'b1;
                    if (mul_end)
                    begin
                        state_next = S_MULD;
                    end
                end
                S_MULD:
                begin
                    cmd.muld_step = 1'b1;
                    cmd.last_step = mul_end;
                    cnt_next      = mul_end ? '0 : cnt_reg + 1'b1;
                    if (mul_end)
                    begin
                        state_next = S_DIV;
                    end
                end
                S_DIV:
                begin
                    cmd.div_step  = 1'b1;
                    cmd.last_step = div_end;
                    cnt_next      = div_end ? '0 : cnt_reg + 1'b1;
                    if (div_end)
                    begin
                        state_next = S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    cmd.sqrt_step = 1'b1;
                    cmd.last_step = sqrt_end;
                    cnt_next      = sqrt_end ? '0 : cnt_reg + 1'b1;
                    if (sqrt_end)
                    begin
                        out_wait_next = 1'b1;
                        state_next    = S_ACC;
                    end
                end
                default:
                begin
                    state_next = S_ACC;
                end
            endcase
        end
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACC;
            out_wait_reg  <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_wait_reg  <= out_wait_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ===== sv/cossim_dp.sv =====
module cossim_dp #(
    parameter int ELEM_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cossim_pkg::cmd_t                    cmd,
    input  logic signed [ELEM_BITS-1:0]         elem_a,
    input  logic signed [ELEM_BITS-1:0]         elem_b,
    output cossim_pkg::status_t                 status,
    output logic signed [cossim_pkg::SIM_W-1:0] similarity,
    output logic                                zero_norm
);

    localparam int PROD_W  = 2 * ELEM_BITS;
    localparam int DACC_W  = (PROD_W > cossim_pkg::DOT_W ? PROD_W : cossim_pkg::DOT_W) + 1;
    localparam int NACC_W  = (PROD_W > cossim_pkg::NORM_W ? PROD_W : cossim_pkg::NORM_W) + 1;
    localparam int DOT_W   = cossim_pkg::DOT_W;
    localparam int NORM_W  = cossim_pkg::NORM_W;
    localparam int MAG_W   = cossim_pkg::MAG_W;
    localparam int MUL_W   = cossim_pkg::MUL_W;
    localparam int P_W     = cossim_pkg::P_W;
    localparam int DVD_W   = cossim_pkg::DVD_W;
    localparam int RAD_W   = cossim_pkg::RAD_W;
    localparam int ROOT_W  = cossim_pkg::ROOT_W;
    localparam int SQREM_W = cossim_pkg::SQREM_W;
    localparam int SIM_W   = cossim_pkg::SIM_W;

    localparam logic signed [DACC_W-1:0] DOT_HI =
        {{(DACC_W - DOT_W + 1){1'b0}}, {(DOT_W - 1){1'b1}}};
    localparam logic signed [DACC_W-1:0] DOT_LO =
        {{(DACC_W - DOT_W + 1){1'b1}}, {(DOT_W - 1){1'b0}}};
    localparam logic [NACC_W-1:0] NORM_HI = {{(NACC_W - NORM_W){1'b0}}, {NORM_W{1'b1}}};

    // input product stage
    logic signed [PROD_W-1:0]  prod_ab_reg;
    logic [PROD_W-1:0]         prod_aa_reg;
    logic [PROD_W-1:0]         prod_bb_reg;
    logic                      prod_valid_reg;
    logic signed [PROD_W-1:0]  ab_full;
    logic signed [PROD_W-1:0]  aa_full;
    logic signed [PROD_W-1:0]  bb_full;

    // running sums
    logic signed [DOT_W-1:0]   dot_reg;
    logic signed [DOT_W-1:0]   dot_next;
    logic [NORM_W-1:0]         na_reg;
    logic [NORM_W-1:0]         na_next;
    logic [NORM_W-1:0]         nb_reg;
    logic [NORM_W-1:0]         nb_next;
    logic signed [DACC_W-1:0]  dot_wide;
    logic [NACC_W-1:0]         na_wide;
    logic [NACC_W-1:0]         nb_wide;

    // shift-add multiplier
    logic [MAG_W-1:0]          mag;
    logic [MAG_W-1:0]          mag_reg;
    logic                      neg_reg;
    logic [MAG_W-1:0]          mcand_reg;
    logic [MAG_W-1:0]          mplier_reg;
    logic [MUL_W-1:0]          macc_reg;
    logic [MUL_W-1:0]          macc_step;
    logic [P_W-1:0]            p_reg;

    // restoring divider
    logic [DVD_W-1:0]          dvd_reg;
    logic [P_W-1:0]            rem_reg;
    logic [P_W:0]              trial;
    logic [P_W+1:0]            diff;
    logic                      qbit;
    logic [RAD_W-1:0]          quo_reg;
    logic                      qsat_reg;

    // digit-by-digit square root
    logic [SQREM_W-1:0]        sqrem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [SQREM_W+1:0]        srem_sh;
    logic [SQREM_W+2:0]        sdiff;
    logic                      sge;
    logic [ROOT_W-1:0]         root_next;
    logic [ROOT_W:0]           root_inc;
    logic [ROOT_W-1:0]         rmag;

    // result staging and output register
    logic signed [SIM_W-1:0]   sim_res_reg;
    logic                      zero_res_reg;
    logic signed [SIM_W-1:0]   sim_out_reg;
    logic                      zero_out_reg;

    assign ab_full = PROD_W'(elem_a * elem_b);
    assign aa_full = PROD_W'(elem_a * elem_a);
    assign bb_full = PROD_W'(elem_b * elem_b);

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            prod_ab_reg <= ab_full;
            prod_aa_reg <= aa_full;
            prod_bb_reg <= bb_full;
        end
    end

    // saturating accumulation
    assign dot_wide = DACC_W'(dot_reg) + DACC_W'(prod_ab_reg);
    assign na_wide  = NACC_W'(na_reg) + NACC_W'(prod_aa_reg);
    assign nb_wide  = NACC_W'(nb_reg) + NACC_W'(prod_bb_reg);

    always_comb
    begin
        if (dot_wide > DOT_HI)
        begin
            dot_next = DOT_HI[DOT_W-1:0];
        end
        else if (dot_wide < DOT_LO)
        begin
            dot_next = DOT_LO[DOT_W-1:0];
        end
        else
        begin
            dot_next = dot_wide[DOT_W-1:0];
        end
        na_next = (na_wide > NORM_HI) ? NORM_HI[NORM_W-1:0] : na_wide[NORM_W-1:0];
        nb_next = (nb_wide > NORM_HI) ? NORM_HI[NORM_W-1:0] : nb_wide[NORM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            dot_reg        <= '0;
            na_reg         <= '0;
            nb_reg         <= '0;
        end
        else
        begin
            prod_valid_reg <= cmd.take;
            if (cmd.load)
            begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end
            else if (prod_valid_reg)
            begin
                dot_reg <= dot_next;
                na_reg  <= na_next;
                nb_reg  <= nb_next;
            end
        end
    end

    assign status.zero_norm = (na_reg == '0) || (nb_reg == '0);

    assign mag = dot_reg[DOT_W-1] ? MAG_W'(~dot_reg + 1'b1) : MAG_W'(dot_reg);

    assign macc_step = {macc_reg[MUL_W-2:0], 1'b0}
                     + (mplier_reg[MAG_W-1] ? MUL_W'(mcand_reg) : '0);

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, p_reg};
    assign qbit  = !diff[P_W+1];

    assign srem_sh   = {sqrem_reg, quo_reg[RAD_W-1:RAD_W-2]};
    assign sdiff     = {1'b0, srem_sh} - (SQREM_W + 3)'({root_reg, 2'b01});
    assign sge       = !sdiff[SQREM_W+2];
    assign root_next = {root_reg[ROOT_W-2:0], sge};
    assign root_inc  = {1'b0, root_next} + 1'b1;
    assign rmag      = qsat_reg ? ROOT_W'(cossim_pkg::ONE_Q14) : root_inc[ROOT_W:1];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg      <= mag;
            neg_reg      <= dot_reg[DOT_W-1];
            mcand_reg    <= MAG_W'(na_reg);
            mplier_reg   <= MAG_W'(nb_reg);
            macc_reg     <= '0;
            zero_res_reg <= status.zero_norm;
            sim_res_reg  <= '0;
        end
        if (cmd.mulp_step || cmd.muld_step)
        begin
            macc_reg   <= macc_step;
            mplier_reg <= {mplier_reg[MAG_W-2:0], 1'b0};
        end
        if (cmd.mulp_step && cmd.last_step)
        begin
            p_reg      <= macc_step[P_W-1:0];
            mcand_reg  <= mag_reg;
            mplier_reg <= mag_reg;
            macc_reg   <= '0;
        end
        if (cmd.muld_step && cmd.last_step)
        begin
            dvd_reg  <= {macc_step, {cossim_pkg::FRAC_SH{1'b0}}};
            rem_reg  <= '0;
            quo_reg  <= '0;
            qsat_reg <= 1'b0;
        end
        if (cmd.div_step)
        begin
            dvd_reg  <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg  <= qbit ? diff[P_W-1:0] : trial[P_W-1:0];
            quo_reg  <= {quo_reg[RAD_W-2:0], qbit};
            qsat_reg <= qsat_reg | quo_reg[RAD_W-1];
            if (cmd.last_step)
            begin
                sqrem_reg <= '0;
                root_reg  <= '0;
            end
        end
        if (cmd.sqrt_step)
        begin
            sqrem_reg <= sge ? sdiff[SQREM_W-1:0] : srem_sh[SQREM_W-1:0];
            root_reg  <= root_next;
            quo_reg   <= {quo_reg[RAD_W-3:0], 2'b00};
            if (cmd.last_step)
            begin
                sim_res_reg  <= neg_reg ? -SIM_W'(rmag) : SIM_W'(rmag);
                zero_res_reg <= 1'b0;
            end
        end
        if (cmd.out_load)
        begin
            sim_out_reg  <= sim_res_reg;
            zero_out_reg <= zero_res_reg;
        end
    end

    assign similarity = sim_out_reg;
    assign zero_norm  = zero_out_reg;

endmodule

// ===== sv/cosine_similarity_vectors.sv =====
// Cosine similarity of two vectors streamed as element pairs (signed Q3.12), one pair
// accepted per cycle while item_ready is high. The pair marked last closes the
// vectors: the block then computes dot / sqrt(norm_a * norm_b) in signed Q1.14,
// rounded to nearest and saturated to +/-1.0, and clears its sums. That final step
// holds off new pairs; it uses a shared 42-step shift-add multiplier twice, a 114-step
// restoring divider and a 15-step square root, plus states that drain the product
// stage, latch operands and hand the result to the output register; when either norm
// is zero it skips the arithmetic and returns 0 with zero_norm set. A finished result
// waits in the output register while the next vector streams in; a new final result
// waits only while the previous one has not been taken.
module cosine_similarity_vectors #(
    parameter int ELEM_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic signed [ELEM_BITS-1:0]         elem_a,
    input  logic signed [ELEM_BITS-1:0]         elem_b,
    input  logic                                last,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic signed [cossim_pkg::SIM_W-1:0] similarity,
    output logic                                zero_norm
);

    cossim_pkg::cmd_t    cmd;
    cossim_pkg::status_t status;

    cossim_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .last         (last),
        .result_ready (result_ready),
        .status       (status),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .cmd          (cmd)
    );

    cossim_dp #(
        .ELEM_BITS (ELEM_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .status     (status),
        .similarity (similarity),
        .zero_norm  (zero_norm)
    );

endmodule

// ===== test/tb_cosine_similarity_vectors.sv =====
module tb_cosine_similarity_vectors;

    localparam int ELEM_W = 16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_PAIRS = 370;
    localparam int STEADY_PAIRS = 60;
    localparam longint DOT_HI = (longint'(1) << (cossim_pkg::DOT_W - 1)) - 1;
    localparam longint DOT_LO = -(longint'(1) << (cossim_pkg::DOT_W - 1));
    localparam longint NORM_HI = (longint'(1) << cossim_pkg::NORM_W) - 1;

    typedef struct packed {
        logic signed [cossim_pkg::SIM_W-1:0] sim_q14;
        logic                                zero_flag;
    } cos_result_t;

    typedef enum int {
        VK_INDEP,
        VK_SAME,
        VK_NEG,
        VK_NEAR,
        VK_ZERO_A,
        VK_ZERO_B
    } vec_kind_t;

    typedef enum int {
        ES_FULL,
        ES_SMALL,
        ES_EDGE
    } elem_style_t;

    logic                                clk;
    logic                                rst_n;
    logic                                item_valid;
    logic                                item_ready;
    logic signed [ELEM_W-1:0]            elem_a;
    logic signed [ELEM_W-1:0]            elem_b;
    logic                                last;
    logic                                result_valid;
    logic                                result_ready;
    logic signed [cossim_pkg::SIM_W-1:0] similarity;
    logic                                zero_norm;

    logic signed [cossim_pkg::DOT_W-1:0] dot_acc;
    logic [cossim_pkg::NORM_W-1:0]       norm_a_acc;
    logic [cossim_pkg::NORM_W-1:0]       norm_b_acc;
    cos_result_t                         pending_sims[$];
    bit                                  failed;
    bit                                  idle_on;
    int                                  pairs_sent;

    cosine_similarity_vectors uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .elem_a       (elem_a),
        .elem_b       (elem_b),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .similarity   (similarity),
        .zero_norm    (zero_norm)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // largest r <= 2^14 with (2r-1)^2 * na * nb <= dot^2 * 2^30, signed like dot
    function automatic cos_result_t cosine_q14(input longint dot, input longint na,
                                               input longint nb);
        bit [127:0]  mag;
        bit [127:0]  rhs;
        bit [127:0]  norm_prod;
        bit [127:0]  d;
        bit [127:0]  lhs;
        int          lo;
        int          hi;
        int          mid;
        cos_result_t res;
        res.sim_q14 = '0;
        res.zero_flag = 1'b0;
        if (na == 0 || nb == 0)
        begin
            res.zero_flag = 1'b1;
            return res;
        end
        mag = (dot < 0) ? 128'(-dot) : 128'(dot);
        rhs = (mag * mag) << cossim_pkg::FRAC_SH;
        norm_prod = 128'(na) * 128'(nb);
        lo = 0;
        hi = cossim_pkg::ONE_Q14;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            d = 128'(2 * mid - 1);
            lhs = d * d * norm_prod;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        res.sim_q14 = cossim_pkg::SIM_W'(lo);
        if (dot < 0)
            res.sim_q14 = -res.sim_q14;
        return res;
    endfunction

    task automatic accumulate_pair(input logic signed [ELEM_W-1:0] a,
                                   input logic signed [ELEM_W-1:0] b, input logic lst);
        longint sum_dot;
        longint sum_a;
        longint sum_b;
        sum_dot = longint'(dot_acc) + longint'(a) * longint'(b);
        if (sum_dot > DOT_HI)
            sum_dot = DOT_HI;
        if (sum_dot < DOT_LO)
            sum_dot = DOT_LO;
        sum_a = longint'(norm_a_acc) + longint'(a) * longint'(a);
        if (sum_a > NORM_HI)
            sum_a = NORM_HI;
        sum_b = longint'(norm_b_acc) + longint'(b) * longint'(b);
        if (sum_b > NORM_HI)
            sum_b = NORM_HI;
        if (lst)
        begin
            pending_sims.push_back(cosine_q14(sum_dot, sum_a, sum_b));
            dot_acc = '0;
            norm_a_acc = '0;
            norm_b_acc = '0;
        end
        else
        begin
            dot_acc = cossim_pkg::DOT_W'(sum_dot);
            norm_a_acc = cossim_pkg::NORM_W'(sum_a);
            norm_b_acc = cossim_pkg::NORM_W'(sum_b);
        end
    endtask

    task automatic send_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b, input logic lst);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        elem_a <= a;
        elem_b <= b;
        last <= lst;
        do
            @(posedge clk);
        while (!item_ready);
        accumulate_pair(a, b, lst);
        pairs_sent++;
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_elem(input elem_style_t st);
        logic signed [ELEM_W-1:0] v;
        case (st)
            ES_FULL:  v = ELEM_W'($urandom_range(0, 65535));
            ES_SMALL: v = ELEM_W'($urandom_range(0, 512)) - 16'sd256;
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = 16'sd0;
                    3:       v = 16'sd1;
                    4:       v = -16'sd1;
                    default: v = 16'sd1 <<< $urandom_range(0, 14);
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_random_vector(input int len);
        vec_kind_t                kind;
        elem_style_t              st;
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        int                       pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            kind = VK_INDEP;
        else if (pick == 4)
            kind = VK_SAME;
        else if (pick == 5)
            kind = VK_NEG;
        else if (pick < 8)
            kind = VK_NEAR;
        else if (pick == 8)
            kind = VK_ZERO_A;
        else
            kind = VK_ZERO_B;
        st = elem_style_t'($urandom_range(ES_FULL, ES_EDGE));
        for (int i = 0; i < len; i++)
        begin
            a = pick_elem(st);
            case (kind)
                VK_INDEP:  b = pick_elem(st);
                VK_SAME:   b = a;
                VK_NEG:    b = -a;
                VK_NEAR:   b = a + ELEM_W'($urandom_range(0, 16)) - 16'sd8;
                VK_ZERO_A:
                begin
                    b = a;
                    a = '0;
                end
                default:   b = '0;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    function automatic int random_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(13, 40);
        return $urandom_range(1, 12);
    endfunction

    task automatic test_directed();
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd5, 1'b1);
        send_pair(-16'sd7, 16'sd0, 1'b1);
        // orthogonal vectors
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd16384, -16'sd16384, 1'b0);
        send_pair(16'sd16384, 16'sd16384, 1'b1);
        send_pair(16'sd1, 16'sh7fff, 1'b0);
        send_pair(16'sh7fff, 16'sd1, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(16'sd4, -16'sd3, 1'b0);
        send_pair(16'sh5555, 16'shaaaa, 1'b1);
        send_pair(-16'sd1, 16'sd2, 1'b0);
        send_pair(16'sd2, 16'sd1, 1'b0);
        send_pair(16'sd0, 16'sd0, 1'b1);
    endtask

    task automatic test_random();
        int start;
        start = pairs_sent;
        while (pairs_sent - start < RANDOM_PAIRS)
            send_random_vector(random_len());
    endtask

    task automatic test_steady();
        int start;
        idle_on = 1'b0;
        start = pairs_sent;
        while (pairs_sent - start < STEADY_PAIRS)
            send_random_vector(random_len());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        elem_a <= '0;
        elem_b <= '0;
        last <= 1'b0;
        dot_acc = '0;
        norm_a_acc = '0;
        norm_b_acc = '0;
        failed = 1'b0;
        idle_on = 1'b1;
        pairs_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_steady();
        item_valid <= 1'b0;
        while (pending_sims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        result_ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cos_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_sims.size() == 0)
            begin
                $error("unexpected result: similarity %0d, zero_norm %0b",
                       similarity, zero_norm);
                failed = 1'b1;
            end
            else
            begin
                want = pending_sims.pop_front();
                if (similarity !== want.sim_q14)
                begin
                    $error("similarity: expected %0d, got %0d", want.sim_q14, similarity);
                    failed = 1'b1;
                end
                if (zero_norm !== want.zero_flag)
                begin
                    $error("zero_norm: expected %0b, got %0b", want.zero_flag, zero_norm);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

endmodule
